// ===== rtl/smalu_pkg.sv =====
`timescale 1ns / 1ps
// Package with the command, status and control types shared by the stack machine ALU.
package smalu_pkg;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned MODE_W  = 5;
  localparam int unsigned DEPTH_W = 9;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,
    OP_NOT   = 5'd1,
    OP_DROP  = 5'd2,
    OP_MOD   = 5'd3,
    OP_SQRT  = 5'd4,
    OP_MUL   = 5'd5,
    OP_SUB   = 5'd6,
    OP_ADD   = 5'd7,
    OP_EQ    = 5'd8,
    OP_SWAP  = 5'd9,
    OP_DUP   = 5'd10,
    OP_NEG   = 5'd11,
    OP_PUTC  = 5'd12,
    OP_PUTN  = 5'd13,
    OP_LT    = 5'd14,
    OP_GT    = 5'd15,
    OP_DIV   = 5'd16,
    OP_DEPTH = 5'd17,
    OP_HALT  = 5'd18
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_STACK = 2'd1,
    KIND_CHAR  = 2'd2,
    KIND_NUM   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_UNDER   = 3'd1,
    STS_DIV0    = 3'd2,
    STS_OVER    = 3'd3,
    STS_NEGROOT = 3'd4,
    STS_HALTED  = 3'd5
  } sts_e;

  // How a command changes the stack when it succeeds.
  typedef enum logic [2:0] {
    WB_NONE,
    WB_PUSH,
    WB_POP,
    WB_BIN,
    WB_UN,
    WB_SWAP
  } wb_e;

  typedef enum logic [1:0] {
    IT_DIV,
    IT_SQRT,
    IT_MUL
  } it_op_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_ITER,
    BS_FIX,
    BS_SWAP
  } bst_e;

  typedef struct packed {
    op_e              op;
    wb_e              wb;
    logic [1:0]       need;
    logic [VAL_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic             start;
    it_op_e           op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } iter_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] res;
    logic [VAL_W-1:0] rem;
  } iter_rsp_t;

endpackage

// ===== rtl/smalu_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
module smalu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/smalu_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words and classifies each command.
module smalu_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [smalu_pkg::MODE_W-1:0]  mode_i,
  input  logic [smalu_pkg::VAL_W-1:0]   operand_i,
  output logic                          wr_valid_o,
  input  logic                          wr_stall_i,
  output smalu_pkg::cmd_t               cmd_o
);

  smalu_pkg::op_e op;

  assign in_stall_o = wr_stall_i;
  assign wr_valid_o = in_valid_i;

  always_comb begin
    if (mode_i > smalu_pkg::MODE_W'(smalu_pkg::OP_HALT)) begin
      op = smalu_pkg::OP_HALT;
    end else begin
      op = smalu_pkg::op_e'(mode_i);
    end
    cmd_o.op      = op;
    cmd_o.operand = operand_i;
    cmd_o.need    = 2'd0;
    cmd_o.wb      = smalu_pkg::WB_NONE;
    unique case (op)
      smalu_pkg::OP_PUSH, smalu_pkg::OP_DEPTH: begin
        cmd_o.wb = smalu_pkg::WB_PUSH;
      end
      smalu_pkg::OP_DUP: begin
        cmd_o.need = 2'd1;
        cmd_o.wb   = smalu_pkg::WB_PUSH;
      end
      smalu_pkg::OP_DROP, smalu_pkg::OP_PUTC, smalu_pkg::OP_PUTN: begin
        cmd_o.need = 2'd1;
        cmd_o.wb   = smalu_pkg::WB_POP;
      end
      smalu_pkg::OP_NOT, smalu_pkg::OP_SQRT, smalu_pkg::OP_NEG: begin
        cmd_o.need = 2'd1;
        cmd_o.wb   = smalu_pkg::WB_UN;
      end
      smalu_pkg::OP_SWAP: begin
        cmd_o.need = 2'd2;
        cmd_o.wb   = smalu_pkg::WB_SWAP;
      end
      smalu_pkg::OP_MOD, smalu_pkg::OP_MUL, smalu_pkg::OP_SUB, smalu_pkg::OP_ADD,
      smalu_pkg::OP_EQ, smalu_pkg::OP_LT, smalu_pkg::OP_GT, smalu_pkg::OP_DIV: begin
        cmd_o.need = 2'd2;
        cmd_o.wb   = smalu_pkg::WB_BIN;
      end
      default: begin
        cmd_o.wb = smalu_pkg::WB_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/smalu_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back end.
module smalu_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_stall_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_pop_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, wp_d;
  logic             rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/smalu_iter.sv =====
`timescale 1ns / 1ps
// Shared multi-cycle unit for unsigned divide, square root and 64-bit multiply.
module smalu_iter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smalu_pkg::iter_req_t  req_i,
  output smalu_pkg::iter_rsp_t  rsp_o
);

  localparam int unsigned W = smalu_pkg::VAL_W;

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [5:0]        last;
  smalu_pkg::it_op_e op_q;
  logic [W-1:0]      a_q, b_q, rem_q, acc_q, prod_q;
  logic [W:0]        div_sh;
  logic [W+2:0]      div_diff;
  logic              div_ge;
  logic [W+1:0]      sq_sh;
  logic [W+1:0]      sq_trial;
  logic [W+2:0]      sq_diff;
  logic              sq_ge;
  logic [31:0]       mul_a, mul_b;

  always_comb begin
    div_sh   = {rem_q, a_q[W-1]};
    div_diff = {2'b00, div_sh} - {3'b000, b_q};
    div_ge   = !div_diff[W+2];
    sq_sh    = {rem_q, a_q[W-1:W-2]};
    sq_trial = {b_q, 2'b01};
    sq_diff  = {1'b0, sq_sh} - {1'b0, sq_trial};
    sq_ge    = !sq_diff[W+2];
    mul_a    = (cnt_q == 6'd2) ? a_q[W-1:32] : a_q[31:0];
    mul_b    = (cnt_q == 6'd1) ? b_q[W-1:32] : b_q[31:0];
    unique case (op_q)
      smalu_pkg::IT_DIV:  last = 6'd63;
      smalu_pkg::IT_SQRT: last = 6'd31;
      default:            last = 6'd3;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      unique case (op_q)
        smalu_pkg::IT_DIV: begin
          rem_q <= div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
          a_q   <= {a_q[W-2:0], div_ge};
        end
        smalu_pkg::IT_SQRT: begin
          rem_q <= sq_ge ? sq_diff[W-1:0] : sq_sh[W-1:0];
          a_q   <= {a_q[W-3:0], 2'b00};
          b_q   <= {b_q[W-2:0], sq_ge};
        end
        smalu_pkg::IT_MUL: begin
          prod_q <= mul_a * mul_b;
          if (cnt_q == 6'd1) begin
            acc_q <= prod_q;
          end else if (cnt_q != 6'd0) begin
            acc_q[W-1:32] <= acc_q[W-1:32] + prod_q[31:0];
          end
        end
        default: begin
          rem_q <= rem_q;
        end
      endcase
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.rem  = rem_q;
    unique case (op_q)
      smalu_pkg::IT_MUL:  rsp_o.res = acc_q;
      smalu_pkg::IT_SQRT: rsp_o.res = b_q;
      default:            rsp_o.res = a_q;
    endcase
  end

endmodule

// ===== rtl/smalu_back.sv =====
`timescale 1ns / 1ps
// Back end: checks and executes commands against the stack and drives result words.
module smalu_back #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_pop_o,
  input  smalu_pkg::cmd_t                cmd_i,
  output smalu_pkg::iter_req_t           iter_req_o,
  input  smalu_pkg::iter_rsp_t           iter_rsp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smalu_pkg::VAL_W-1:0]    result_value_o,
  output logic [1:0]                     value_kind_o,
  output logic [2:0]                     status_o,
  output logic [smalu_pkg::DEPTH_W-1:0]  stack_depth_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W  = smalu_pkg::VAL_W;

  smalu_pkg::bst_e  state_q, state_d;
  smalu_pkg::cmd_t  cmd_q, cmd_d;
  logic [PW-1:0]    sp_q, sp_d, sp_m1, sp_m2;
  logic             halted_q, halted_d;
  logic [W-1:0]     top_q, top_d, nxt_q, nxt_d;
  logic             neg_q, neg_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     res_q, res_d;
  smalu_pkg::kind_e kind_q, kind_d;
  smalu_pkg::sts_e  sts_q, sts_d;
  logic [PW-1:0]    dep_q, dep_d;
  logic [PW+8:0]    dep_ext;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [W-1:0]     wdata;
  logic [W-1:0]     rd_a, rd_b;

  logic             fin;
  logic [W-1:0]     fin_value;
  logic [W-1:0]     raw;
  smalu_pkg::kind_e fin_kind;
  smalu_pkg::sts_e  fin_sts;

  assign sp_m1 = sp_q - PW'(1);
  assign sp_m2 = sp_q - PW'(2);

  smalu_ram #(
    .WIDTH(W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(sp_m1[AW-1:0]),
    .rdata_a_o(rd_a),
    .raddr_b_i(sp_m2[AW-1:0]),
    .rdata_b_o(rd_b)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sp_d        = sp_q;
    halted_d    = halted_q;
    top_d       = top_q;
    nxt_d       = nxt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    kind_d      = kind_q;
    sts_d       = sts_q;
    dep_d       = dep_q;
    cmd_pop_o   = 1'b0;
    iter_req_o  = '0;
    we          = 1'b0;
    waddr       = sp_m1[AW-1:0];
    wdata       = nxt_q;
    fin         = 1'b0;
    fin_value   = '0;
    fin_kind    = smalu_pkg::KIND_STACK;
    fin_sts     = smalu_pkg::STS_OK;
    raw         = (cmd_q.op == smalu_pkg::OP_MOD) ? iter_rsp_i.rem : iter_rsp_i.res;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      smalu_pkg::BS_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = smalu_pkg::BS_EXEC;
        end
      end
      smalu_pkg::BS_EXEC: begin
        top_d   = rd_a;
        nxt_d   = rd_b;
        fin     = 1'b1;
        state_d = smalu_pkg::BS_IDLE;
        priority if (halted_q || cmd_q.op == smalu_pkg::OP_HALT) begin
          fin_sts = smalu_pkg::STS_HALTED;
        end else if (sp_q < PW'(cmd_q.need)) begin
          fin_sts = smalu_pkg::STS_UNDER;
        end else if (cmd_q.wb == smalu_pkg::WB_PUSH && sp_q == PW'(STACK_DEPTH)) begin
          fin_sts = smalu_pkg::STS_OVER;
        end else begin
          unique case (cmd_q.op)
            smalu_pkg::OP_PUSH:  fin_value = cmd_q.operand;
            smalu_pkg::OP_DEPTH: fin_value = W'(sp_q);
            smalu_pkg::OP_DUP, smalu_pkg::OP_DROP: fin_value = rd_a;
            smalu_pkg::OP_NOT:   fin_value = W'(rd_a == '0);
            smalu_pkg::OP_NEG:   fin_value = '0 - rd_a;
            smalu_pkg::OP_PUTC: begin
              fin_value = W'(rd_a[7:0]);
              fin_kind  = smalu_pkg::KIND_CHAR;
            end
            smalu_pkg::OP_PUTN: begin
              fin_value = rd_a;
              fin_kind  = smalu_pkg::KIND_NUM;
            end
            smalu_pkg::OP_ADD: fin_value = rd_b + rd_a;
            smalu_pkg::OP_SUB: fin_value = rd_b - rd_a;
            smalu_pkg::OP_EQ:  fin_value = W'(rd_b == rd_a);
            smalu_pkg::OP_LT:  fin_value = W'($signed(rd_b) < $signed(rd_a));
            smalu_pkg::OP_GT:  fin_value = W'($signed(rd_b) > $signed(rd_a));
            smalu_pkg::OP_SWAP: begin
              fin_value = rd_b;
              state_d   = smalu_pkg::BS_SWAP;
            end
            smalu_pkg::OP_MUL: begin
              fin              = 1'b0;
              neg_d            = 1'b0;
              iter_req_o.start = 1'b1;
              iter_req_o.op    = smalu_pkg::IT_MUL;
              iter_req_o.a     = rd_b;
              iter_req_o.b     = rd_a;
              state_d          = smalu_pkg::BS_ITER;
            end
            smalu_pkg::OP_SQRT: begin
              if (rd_a[W-1]) begin
                fin_sts = smalu_pkg::STS_NEGROOT;
              end else begin
                fin              = 1'b0;
                neg_d            = 1'b0;
                iter_req_o.start = 1'b1;
                iter_req_o.op    = smalu_pkg::IT_SQRT;
                iter_req_o.a     = rd_a;
                iter_req_o.b     = '0;
                state_d          = smalu_pkg::BS_ITER;
              end
            end
            smalu_pkg::OP_DIV, smalu_pkg::OP_MOD: begin
              if (rd_a == '0) begin
                fin_sts = smalu_pkg::STS_DIV0;
              end else begin
                fin              = 1'b0;
                neg_d            = (cmd_q.op == smalu_pkg::OP_DIV) ? (rd_b[W-1] ^ rd_a[W-1])
                                                                   : rd_b[W-1];
                iter_req_o.start = 1'b1;
                iter_req_o.op    = smalu_pkg::IT_DIV;
                iter_req_o.a     = rd_b[W-1] ? ('0 - rd_b) : rd_b;
                iter_req_o.b     = rd_a[W-1] ? ('0 - rd_a) : rd_a;
                state_d          = smalu_pkg::BS_ITER;
              end
            end
            default: begin
              fin_sts = smalu_pkg::STS_HALTED;
            end
          endcase
        end
      end
      smalu_pkg::BS_ITER: begin
        if (iter_rsp_i.done) begin
          state_d = smalu_pkg::BS_FIX;
        end
      end
      smalu_pkg::BS_FIX: begin
        fin       = 1'b1;
        fin_value = neg_q ? ('0 - raw) : raw;
        state_d   = smalu_pkg::BS_IDLE;
      end
      smalu_pkg::BS_SWAP: begin
        we      = 1'b1;
        waddr   = sp_m2[AW-1:0];
        wdata   = top_q;
        state_d = smalu_pkg::BS_IDLE;
      end
      default: begin
        state_d = smalu_pkg::BS_IDLE;
      end
    endcase

    if (fin) begin
      if (fin_sts != smalu_pkg::STS_OK) begin
        halted_d  = 1'b1;
        fin_value = '0;
        fin_kind  = smalu_pkg::KIND_NONE;
        state_d   = smalu_pkg::BS_IDLE;
      end else begin
        unique case (cmd_q.wb)
          smalu_pkg::WB_PUSH: begin
            we    = 1'b1;
            waddr = sp_q[AW-1:0];
            wdata = fin_value;
            sp_d  = sp_q + PW'(1);
          end
          smalu_pkg::WB_POP: begin
            sp_d = sp_m1;
          end
          smalu_pkg::WB_BIN: begin
            we    = 1'b1;
            waddr = sp_m2[AW-1:0];
            wdata = fin_value;
            sp_d  = sp_m1;
          end
          smalu_pkg::WB_UN, smalu_pkg::WB_SWAP: begin
            we    = 1'b1;
            waddr = sp_m1[AW-1:0];
            wdata = fin_value;
          end
          default: begin
            sp_d = sp_q;
          end
        endcase
      end
      out_valid_d = 1'b1;
      res_d       = fin_value;
      kind_d      = fin_kind;
      sts_d       = fin_sts;
      dep_d       = sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smalu_pkg::BS_IDLE;
      sp_q        <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    top_q  <= top_d;
    nxt_q  <= nxt_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    kind_q <= kind_d;
    sts_q  <= sts_d;
    dep_q  <= dep_d;
  end

  assign dep_ext        = {9'd0, dep_q};
  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign value_kind_o   = kind_q;
  assign status_o       = sts_q;
  assign stack_depth_o  = dep_ext[8:0];

endmodule

// ===== rtl/stack_machine_alu_unit.sv =====
`timescale 1ns / 1ps
// Top level of the 64-bit stack machine ALU.
//
//   Channel | Direction | Handshake              | Word fields
//   in      | input     | in_valid_i, in_stall_o   | mode_i, operand_i
//   out     | output    | out_valid_o, out_stall_i | result_value_o, value_kind_o,
//           |           |                          | status_o, stack_depth_o
//
// A command's result word is worked out in the execute state after the back end takes
// it, then registered; multiply, square root, divide and modulo pass through the shared
// iterative unit, which retires one quotient bit or one root bit per cycle, and a fix-up
// state. Swap adds a write state; a new command starts the cycle after a word is taken.
// A two-entry queue lets the front end take words while the back end works.
// Reset clears the stack pointer and the halt flag; the stack memory is not cleared.
// A stalled result holds the back end; the queue then fills and stalls the input.
module stack_machine_alu_unit #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [smalu_pkg::MODE_W-1:0]  mode_i,
  input  logic [smalu_pkg::VAL_W-1:0]   operand_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [smalu_pkg::VAL_W-1:0]   result_value_o,
  output logic [1:0]                    value_kind_o,
  output logic [2:0]                    status_o,
  output logic [smalu_pkg::DEPTH_W-1:0] stack_depth_o
);

  smalu_pkg::cmd_t      front_cmd;
  smalu_pkg::cmd_t      back_cmd;
  logic                 wr_valid;
  logic                 wr_stall;
  logic                 rd_valid;
  logic                 rd_pop;
  smalu_pkg::iter_req_t iter_req;
  smalu_pkg::iter_rsp_t iter_rsp;

  smalu_front u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .mode_i    (mode_i),
    .operand_i (operand_i),
    .wr_valid_o(wr_valid),
    .wr_stall_i(wr_stall),
    .cmd_o     (front_cmd)
  );

  smalu_fifo #(
    .WIDTH($bits(smalu_pkg::cmd_t))
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(wr_valid),
    .wr_stall_o(wr_stall),
    .wr_data_i (front_cmd),
    .rd_valid_o(rd_valid),
    .rd_pop_i  (rd_pop),
    .rd_data_o (back_cmd)
  );

  smalu_iter u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (iter_req),
    .rsp_o (iter_rsp)
  );

  smalu_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (rd_valid),
    .cmd_pop_o     (rd_pop),
    .cmd_i         (back_cmd),
    .iter_req_o    (iter_req),
    .iter_rsp_i    (iter_rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .value_kind_o  (value_kind_o),
    .status_o      (status_o),
    .stack_depth_o (stack_depth_o)
  );

endmodule

// ===== rtl/smalu_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stack machine ALU and its bind to the top level.
module smalu_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [smalu_pkg::MODE_W-1:0]  mode_i,
  input logic [smalu_pkg::VAL_W-1:0]   operand_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [smalu_pkg::VAL_W-1:0]   result_value_o,
  input logic [1:0]                    value_kind_o,
  input logic [2:0]                    status_o,
  input logic [smalu_pkg::DEPTH_W-1:0] stack_depth_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(status_o) && $stable(stack_depth_o))
    else $error("Stalled result word changed.");

  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 3'(smalu_pkg::STS_OK) |->
      result_value_o == '0 && value_kind_o == 2'(smalu_pkg::KIND_NONE))
    else $error("Error word carries a value.");

  a_char_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_kind_o == 2'(smalu_pkg::KIND_CHAR) |->
      result_value_o[smalu_pkg::VAL_W-1:8] == '0)
    else $error("Character word wider than a byte.");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("Result word valid right after reset.");

endmodule

bind stack_machine_alu_unit smalu_chk u_chk (.*);
